>>> src/base64_decoder_stream_assert.svh
// Assertion macros used by the base64 decoder checker.
`ifndef BASE64_DECODER_STREAM_ASSERT_SVH
`define BASE64_DECODER_STREAM_ASSERT_SVH

// check consequent in the same cycle as the antecedent
`define B64D_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// check consequent in the cycle after the antecedent
`define B64D_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

>>> src/b64d_pkg.sv
// Shared types, constants and character classifier for the base64 decoder.
package b64d_pkg;

	localparam int unsigned MAX_BYTES_DEF   = 2048;
	localparam int unsigned QUEUE_DEPTH_DEF = 8;
	localparam int unsigned LEN_W           = 12;
	localparam logic [LEN_W-1:0] CAP_RESET  = 12'd2048;

	typedef enum logic [1:0] {
		CLS_OK  = 2'd0,
		CLS_PAD = 2'd1,
		CLS_BAD = 2'd2
	} class_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADCHAR  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0][7:0]  bytes;
		logic [1:0]       nbytes;
		logic [LEN_W-1:0] start_len;
		logic             summary;
		status_t          status;
	} job_t;

	typedef struct packed {
		logic [5:0] sextet;
		class_t     cls;
	} char_info_t;

	function automatic char_info_t classify(input logic [7:0] ch);
		char_info_t r;
		r.sextet = 6'd0;
		r.cls    = CLS_OK;
		if (ch >= 8'h41 && ch <= 8'h5A) begin
			r.sextet = 6'(ch - 8'h41);
		end else if (ch >= 8'h61 && ch <= 8'h7A) begin
			r.sextet = 6'(ch - 8'h61 + 8'd26);
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			r.sextet = 6'(ch - 8'h30 + 8'd52);
		end else if (ch == 8'h2B) begin
			r.sextet = 6'd62;
		end else if (ch == 8'h2F) begin
			r.sextet = 6'd63;
		end else if (ch == 8'h3D) begin
			r.cls = CLS_PAD;
		end else begin
			r.cls = CLS_BAD;
		end
		return r;
	endfunction

endpackage

>>> src/b64d_front.sv
// Front end: character intake, group assembly, capacity and error tracking.
module b64d_front #(
	parameter int unsigned MAX_BYTES = 2048
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [7:0]                   code_char,
	input  logic                         last_char,
	input  logic                         cfg_wr,
	input  logic [b64d_pkg::LEN_W-1:0]   cfg_data,
	output logic                         push,
	output b64d_pkg::job_t               push_job
);
	import b64d_pkg::*;

	localparam int unsigned MAX_CAP_I = (MAX_BYTES > 4095) ? 4095 : MAX_BYTES;
	localparam logic [LEN_W-1:0] MAX_CAP = LEN_W'(MAX_CAP_I);

	logic [LEN_W-1:0] cap_cfg_q;
	logic [1:0]       pos_q;
	logic [5:0]       sext_q [3];
	class_t           cls_q [3];
	logic [LEN_W-1:0] cnt_q;
	status_t          err_q;

	char_info_t       ci;
	logic             accept;
	logic [LEN_W-1:0] cap;
	logic [LEN_W-1:0] room;
	logic [1:0]       want;
	logic             bad;
	logic             ovf;
	logic [1:0]       emit;
	status_t          err_n;
	logic [LEN_W-1:0] cnt_n;

	always_comb begin
		ci     = classify(code_char);
		accept = in_valid && !in_stall;
		cap    = (cap_cfg_q > MAX_CAP) ? MAX_CAP : cap_cfg_q;
		room   = (cnt_q >= cap) ? '0 : cap - cnt_q;
		want   = 2'd0;
		bad    = 1'b0;
		if (pos_q == 2'd3 && err_q == ST_OK) begin
			if (cls_q[0] != CLS_OK || cls_q[1] != CLS_OK) begin
				bad = 1'b1;
			end else if (cls_q[2] == CLS_PAD) begin
				want = 2'd1;
			end else if (cls_q[2] != CLS_OK) begin
				want = 2'd1;
				bad  = 1'b1;
			end else if (ci.cls == CLS_PAD) begin
				want = 2'd2;
			end else if (ci.cls != CLS_OK) begin
				want = 2'd2;
				bad  = 1'b1;
			end else begin
				want = 2'd3;
			end
		end
		ovf   = {{(LEN_W-2){1'b0}}, want} > room;
		emit  = ovf ? room[1:0] : want;
		err_n = ovf ? ST_OVERFLOW : (bad ? ST_BADCHAR : err_q);
		cnt_n = cnt_q + {{(LEN_W-2){1'b0}}, emit};

		push_job.bytes[0]  = {sext_q[0], sext_q[1][5:4]};
		push_job.bytes[1]  = {sext_q[1][3:0], sext_q[2][5:2]};
		push_job.bytes[2]  = {sext_q[2][1:0], ci.sextet};
		push_job.nbytes    = emit;
		push_job.start_len = cnt_q;
		push_job.summary   = last_char;
		push_job.status    = err_n;
		push = accept && (emit != 2'd0 || last_char);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_cfg_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_cfg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
			cnt_q <= '0;
			err_q <= ST_OK;
		end else if (accept) begin
			if (last_char) begin
				pos_q <= 2'd0;
				cnt_q <= '0;
				err_q <= ST_OK;
			end else begin
				pos_q <= pos_q + 2'd1;
				cnt_q <= cnt_n;
				err_q <= err_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pos_q != 2'd3) begin
			sext_q[pos_q] <= ci.sextet;
			cls_q[pos_q]  <= ci.cls;
		end
	end

endmodule

>>> src/b64d_fifo.sv
// Job queue between the decoder front end and the output sequencer.
module b64d_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64d_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output b64d_pkg::job_t head_job
);
	import b64d_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (cnt_q == FULL_CNT);
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

>>> src/b64d_back.sv
// Back end: expands queued jobs into byte and summary words on the output channel.
module b64d_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  b64d_pkg::job_t             head_job,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 data_byte,
	output logic                       byte_valid,
	output logic                       done_res,
	output logic [1:0]                 status,
	output logic [b64d_pkg::LEN_W-1:0] decoded_length
);
	import b64d_pkg::*;

	logic [1:0]       idx_q;
	logic             out_valid_q;
	logic [7:0]       data_q;
	logic             byte_valid_q;
	logic             done_q;
	logic [1:0]       status_q;
	logic [LEN_W-1:0] len_q;

	logic             is_byte;
	logic             job_end;
	logic             load;
	logic [7:0]       sel_byte;
	logic [LEN_W-1:0] byte_len;
	logic [LEN_W-1:0] sum_len;

	always_comb begin
		is_byte = idx_q < head_job.nbytes;
		job_end = is_byte ? (idx_q == head_job.nbytes - 2'd1 && !head_job.summary) : 1'b1;
		load    = head_valid && (!out_valid_q || !out_stall);
		pop     = load && job_end;
		case (idx_q)
			2'd0:    sel_byte = head_job.bytes[0];
			2'd1:    sel_byte = head_job.bytes[1];
			2'd2:    sel_byte = head_job.bytes[2];
			default: sel_byte = 8'd0;
		endcase
		byte_len = head_job.start_len + {{(LEN_W-2){1'b0}}, idx_q} + LEN_W'(1);
		sum_len  = head_job.start_len + {{(LEN_W-2){1'b0}}, head_job.nbytes};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			idx_q       <= job_end ? 2'd0 : idx_q + 2'd1;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q       <= is_byte ? sel_byte : 8'd0;
			byte_valid_q <= is_byte;
			done_q       <= !is_byte;
			status_q     <= is_byte ? ST_OK : head_job.status;
			len_q        <= is_byte ? byte_len : sum_len;
		end
	end

	assign out_valid      = out_valid_q;
	assign data_byte      = data_q;
	assign byte_valid     = byte_valid_q;
	assign done_res       = done_q;
	assign status         = status_q;
	assign decoded_length = len_q;

endmodule

>>> src/base64_decoder_stream.sv
// Streaming base64 decoder top level.
//
// Input channel (in_valid/in_stall, code_char, last_char): one text character
// per word, last_char marks the final character of a message.
// Output channel (out_valid/out_stall): each word is either a decoded byte
// (byte_valid=1) or, after the last character, a summary (done_res=1) with
// status and the final decoded_length.
// Config channel (cfg_valid/cfg_ready, cfg_data): output capacity in bytes;
// cfg_ready is always high.
// Throughput: one character per cycle while in_stall is low, and one
// output word per cycle while out_stall is low. A decoded group's bytes
// are written into the job queue and then into the output register.
// When the receiver stalls, the output word holds and the job queue fills;
// in_stall rises once the queue holds QUEUE_DEPTH jobs.
// Reset clears the group, the byte count, the error status and the queue,
// and sets the capacity to 2048.
module base64_decoder_stream #(
	parameter int unsigned MAX_BYTES   = b64d_pkg::MAX_BYTES_DEF,
	parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 code_char,
	input  logic                       last_char,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [b64d_pkg::LEN_W-1:0] cfg_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 data_byte,
	output logic                       byte_valid,
	output logic                       done_res,
	output logic [1:0]                 status,
	output logic [b64d_pkg::LEN_W-1:0] decoded_length
);
	import b64d_pkg::*;

	logic push;
	job_t push_job;
	logic full;
	logic pop;
	logic head_valid;
	job_t head_job;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;

	b64d_front #(
		.MAX_BYTES(MAX_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (full),
		.code_char(code_char),
		.last_char(last_char),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.push     (push),
		.push_job (push_job)
	);

	b64d_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_job  (head_job)
	);

	b64d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_job      (head_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.data_byte     (data_byte),
		.byte_valid    (byte_valid),
		.done_res      (done_res),
		.status        (status),
		.decoded_length(decoded_length)
	);

endmodule

>>> src/b64d_checker.sv
// Port-level checker for the base64 decoder, bound to the top level.
`include "base64_decoder_stream_assert.svh"

module b64d_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [7:0]                 data_byte,
	input logic                       byte_valid,
	input logic                       done_res,
	input logic [1:0]                 status,
	input logic [b64d_pkg::LEN_W-1:0] decoded_length
);
	import b64d_pkg::*;

	logic [LEN_W-1:0] prev_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_len_q <= '0;
		end else if (out_valid && !out_stall) begin
			prev_len_q <= done_res ? '0 : decoded_length;
		end
	end

	`B64D_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(data_byte) && $stable(decoded_length) && $stable(done_res))
	`B64D_ASSERT_NOW(a_kind_excl, out_valid, byte_valid != done_res)
	`B64D_ASSERT_NOW(a_byte_len, out_valid && byte_valid, status == ST_OK && decoded_length == prev_len_q + LEN_W'(1))
	`B64D_ASSERT_NOW(a_sum_len, out_valid && done_res, decoded_length == prev_len_q)

endmodule

bind base64_decoder_stream b64d_checker u_chk (.*);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for base64_decoder_stream: directed and random text checked against a decoder model.
module tb_top;
	import b64d_pkg::*;

	localparam logic [7:0] PAD_CHAR     = 8'h3D;
	localparam int         FLUSH_CYCLES = 8;
	localparam int         CHUNK_CHARS  = 24;

	typedef struct packed {
		logic [7:0]       data;
		logic             is_byte;
		logic             is_done;
		status_t          st;
		logic [LEN_W-1:0] len;
	} out_word_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [7:0]       code_char;
	logic             last_char;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [LEN_W-1:0] cfg_data;
	logic             out_valid;
	logic             out_stall;
	logic [7:0]       data_byte;
	logic             byte_valid;
	logic             done_res;
	logic [1:0]       status;
	logic [LEN_W-1:0] decoded_length;

	out_word_t decoded_words[$];
	int        mismatches    = 0;
	int        chars_sent    = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	logic      hold_active   = 1'b0;

	logic [1:0]       grp_pos;
	logic [5:0]       held_sx [3];
	class_t           held_cls [3];
	logic [LEN_W-1:0] byte_cnt;
	status_t          err_state;
	logic [LEN_W-1:0] cap_bytes;

	base64_decoder_stream i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.code_char      (code_char),
		.last_char      (last_char),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.done_res       (done_res),
		.status         (status),
		.decoded_length (decoded_length)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void sort_char(input logic [7:0] ch, output logic [5:0] sx,
			output class_t cl);
		sx = 6'd0;
		cl = CLS_OK;
		if (ch >= "A" && ch <= "Z") begin
			sx = 6'(ch - "A");
		end else if (ch >= "a" && ch <= "z") begin
			sx = 6'(ch - "a" + 26);
		end else if (ch >= "0" && ch <= "9") begin
			sx = 6'(ch - "0" + 52);
		end else if (ch == "+") begin
			sx = 6'd62;
		end else if (ch == "/") begin
			sx = 6'd63;
		end else if (ch == PAD_CHAR) begin
			cl = CLS_PAD;
		end else begin
			cl = CLS_BAD;
		end
	endfunction

	function automatic bit push_byte(input logic [7:0] v);
		int        limit;
		out_word_t w;
		limit = (cap_bytes > MAX_BYTES_DEF) ? MAX_BYTES_DEF : int'(cap_bytes);
		if (int'(byte_cnt) + 1 > limit) begin
			err_state = ST_OVERFLOW;
			return 1'b0;
		end
		byte_cnt++;
		w.data    = v;
		w.is_byte = 1'b1;
		w.is_done = 1'b0;
		w.st      = ST_OK;
		w.len     = byte_cnt;
		decoded_words.push_back(w);
		return 1'b1;
	endfunction

	function automatic void decode_group(input logic [5:0] s3, input class_t c3);
		if (held_cls[0] != CLS_OK || held_cls[1] != CLS_OK) begin
			err_state = ST_BADCHAR;
			return;
		end
		if (!push_byte({held_sx[0], held_sx[1][5:4]})) return;
		if (held_cls[2] == CLS_PAD) return;
		if (held_cls[2] != CLS_OK) begin
			err_state = ST_BADCHAR;
			return;
		end
		if (!push_byte({held_sx[1][3:0], held_sx[2][5:2]})) return;
		if (c3 == CLS_PAD) return;
		if (c3 != CLS_OK) begin
			err_state = ST_BADCHAR;
			return;
		end
		void'(push_byte({held_sx[2][1:0], s3}));
	endfunction

	function automatic void predict_char(input logic [7:0] ch, input logic last);
		logic [5:0] sx;
		class_t     cl;
		out_word_t  w;
		sort_char(ch, sx, cl);
		if (grp_pos < 2'd3) begin
			held_sx[grp_pos]  = sx;
			held_cls[grp_pos] = cl;
			grp_pos++;
		end else begin
			if (err_state == ST_OK) decode_group(sx, cl);
			grp_pos = 2'd0;
		end
		if (last) begin
			w.data    = 8'd0;
			w.is_byte = 1'b0;
			w.is_done = 1'b1;
			w.st      = err_state;
			w.len     = byte_cnt;
			decoded_words.push_back(w);
			grp_pos   = 2'd0;
			byte_cnt  = '0;
			err_state = ST_OK;
		end
	endfunction

	function automatic logic [7:0] alpha_char(input logic [5:0] v);
		if (v < 26) return 8'("A" + v);
		if (v < 52) return 8'("a" + v - 26);
		if (v < 62) return 8'("0" + v - 52);
		if (v == 62) return 8'("+");
		return 8'("/");
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch in %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
		mismatches++;
	endtask

	task automatic check_word();
		out_word_t want;
		if (decoded_words.size() == 0) begin
			report_mismatch("unexpected word", data_byte, 0);
			return;
		end
		want = decoded_words.pop_front();
		if (data_byte !== want.data) report_mismatch("data_byte", data_byte, want.data);
		if (byte_valid !== want.is_byte) report_mismatch("byte_valid", byte_valid, want.is_byte);
		if (done_res !== want.is_done) report_mismatch("done_res", done_res, want.is_done);
		if (status !== want.st) report_mismatch("status", status, want.st);
		if (decoded_length !== want.len)
			report_mismatch("decoded_length", decoded_length, want.len);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) check_word();
		out_stall <= hold_active || ($urandom_range(99) < recv_idle_pct);
	end

	task automatic send_char(input logic [7:0] ch, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		code_char <= ch;
		last_char <= last;
		do @(posedge clk); while (in_stall);
		predict_char(ch, last);
		chars_sent++;
	endtask

	task automatic send_text(input string s, input bit last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], last_at_end && (i == s.len() - 1));
	endtask

	task automatic drain_words();
		in_valid <= 1'b0;
		while (decoded_words.size() != 0) @(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [LEN_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_bytes = v;
	endtask

	task automatic hold_receiver(input int cycles);
		fork
			begin
				hold_active <= 1'b1;
				repeat (cycles) @(posedge clk);
				hold_active <= 1'b0;
			end
		join_none
	endtask

	task automatic send_random_message(input int noise_pct);
		logic [7:0] text[$];
		int         n_groups;
		int         pad;
		n_groups = $urandom_range(1, 6);
		for (int i = 0; i < n_groups * 4; i++) text.push_back(alpha_char(6'($urandom_range(0, 63))));
		pad = $urandom_range(0, 3);
		if (pad >= 2) text[text.size() - 1] = PAD_CHAR;
		if (pad == 3) text[text.size() - 2] = PAD_CHAR;
		if ($urandom_range(99) < noise_pct)
			text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(1, 255));
		if ($urandom_range(99) < noise_pct / 2)
			text[$urandom_range(0, text.size() - 1)] = PAD_CHAR;
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(1, 3)) void'(text.pop_back());
		foreach (text[i]) send_char(text[i], i == text.size() - 1);
	endtask

	task automatic test_directed_groups();
		// range edges of the alphabet, then padding in the third place with a bad fourth
		send_text("AZaz09+/TQ=*", 1);
		// padding in the fourth place, trailing partial group dropped
		send_text("TWE=A", 1);
		// bad fourth character, later group held but not decoded
		send_text("TWE*AAAA", 1);
		send_text("=AAA", 1);
		send_char(8'hFF, 1'b1);
		send_char(8'h01, 1'b1);
	endtask

	task automatic test_capacity_limits();
		drain_words();
		write_capacity('0);
		send_text("QUJD", 1);
		drain_words();
		write_capacity(LEN_W'(1));
		send_text("QUJD", 1);
		drain_words();
		write_capacity(LEN_W'(3));
		send_text("QUJDRA==", 1);
		drain_words();
		write_capacity(CAP_RESET);
	endtask

	task automatic test_random_stream(input int s_pct, input int r_pct, input bit pressure);
		int start;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int chunk = 0; chunk < 3; chunk++) begin
			drain_words();
			case ($urandom_range(0, 3))
				0: write_capacity(LEN_W'($urandom_range(0, 2048)));
				1: write_capacity(LEN_W'($urandom_range(0, 12)));
				default: write_capacity(CAP_RESET);
			endcase
			if (pressure && chunk == 1) hold_receiver(80);
			start = chars_sent;
			while (chars_sent - start < CHUNK_CHARS) send_random_message(20);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		code_char = 8'd0;
		last_char = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		out_stall = 1'b0;
		grp_pos   = 2'd0;
		byte_cnt  = '0;
		err_state = ST_OK;
		cap_bytes = CAP_RESET;
		for (int i = 0; i < 3; i++) begin
			held_sx[i]  = 6'd0;
			held_cls[i] = CLS_OK;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 37;
		recv_idle_pct = 53;
		test_directed_groups();
		test_capacity_limits();
		test_random_stream(37, 53, 1'b0);
		test_random_stream(53, 37, 1'b0);
		test_random_stream(0, 0, 1'b1);
		drain_words();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> base64_decoder_stream.f
+incdir+src
src/b64d_pkg.sv
src/b64d_front.sv
src/b64d_fifo.sv
src/b64d_back.sv
src/base64_decoder_stream.sv
src/b64d_checker.sv
sim/tb_top.sv
